[hdl/one_wire_half_duplex_uart_defines.svh]
// ---------------------------------------------------------------------------
// One-wire UART assertion macros
// Shared property forms for the checker; clocked on clk, off in reset.
// ---------------------------------------------------------------------------
`ifndef ONE_WIRE_HALF_DUPLEX_UART_DEFINES_SVH
`define ONE_WIRE_HALF_DUPLEX_UART_DEFINES_SVH

// same-cycle implication
`define OWU_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define OWU_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/owu_pkg.sv]
// ---------------------------------------------------------------------------
// owu_pkg
// Types and constants shared by the one-wire UART modules.
// ---------------------------------------------------------------------------
package owu_pkg;

	// receive FIFO
	localparam int FIFO_DEPTH = 64;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = 6;

	// field and register widths
	localparam int BT_W      = 14;
	localparam int TRIM_W    = 10;
	localparam int TIME_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_W     = 14;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BIT_TICKS   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_TRIM = 1'd1;

	localparam logic [BT_W-1:0]   BIT_TICKS_RST   = 14'd128;
	localparam logic [TRIM_W-1:0] CENTER_TRIM_RST = 10'd120;

	// item commands
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_SEND  = 2'd1;
	localparam logic [1:0] MODE_BREAK = 2'd2;
	localparam logic [1:0] MODE_POP   = 2'd3;

	// bit counts loaded at start of a frame
	localparam logic [3:0] BITS_RX  = 4'd8;
	localparam logic [3:0] BITS_TX  = 4'd9;
	localparam logic [3:0] BITS_BRK = 4'd15;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_RX,
		PH_TX,
		PH_BRK
	} phase_t;

	// line engine result for one tick
	typedef struct packed {
		logic       drive;
		logic       accepted;
		logic       push;
		logic [7:0] push_byte;
		logic       busy;
	} eng_out_t;

endpackage

[hdl/owu_ram.sv]
// ---------------------------------------------------------------------------
// owu_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module owu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[hdl/owu_engine.sv]
// ---------------------------------------------------------------------------
// owu_engine
// Bit timer plus receive / transmit / break sequencer, one step per tick.
// ---------------------------------------------------------------------------
module owu_engine (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic [1:0]                     mode,
	input  logic                           line_in,
	input  logic [7:0]                     tx_byte,
	input  logic                           tx_more,
	input  logic [owu_pkg::BT_W-1:0]       bit_ticks,
	input  logic [owu_pkg::TRIM_W-1:0]     center_trim,
	output owu_pkg::eng_out_t              eng
);

	owu_pkg::phase_t phase_q, phase_d;
	logic [owu_pkg::TIME_W-1:0] tick_q, tick_d, event_q, event_d, tick_inc;
	logic [7:0] shift_q, shift_d;
	logic [3:0] bits_q, bits_d;
	logic       gap_q, gap_d;
	logic       drive_q, drive_d;
	logic       accepted, push, fire;

	logic [owu_pkg::BT_W:0]   bt_x15;
	logic [owu_pkg::BT_W:0]   first_dly;
	logic [owu_pkg::BT_W+1:0] bt_x3;
	logic [owu_pkg::TIME_W-1:0] bit_time, first_time, stop_time;

	// interval lengths from the current registers
	assign bt_x15    = {1'b0, bit_ticks} + {2'b00, bit_ticks[owu_pkg::BT_W-1:1]};
	assign first_dly = (bt_x15 > (owu_pkg::BT_W+1)'(center_trim))
		? bt_x15 - (owu_pkg::BT_W+1)'(center_trim)
		: (owu_pkg::BT_W+1)'(1);
	assign bt_x3     = {2'b00, bit_ticks} + {1'b0, bit_ticks, 1'b0};
	assign bit_time   = owu_pkg::TIME_W'(bit_ticks);
	assign first_time = owu_pkg::TIME_W'(first_dly);
	assign stop_time  = owu_pkg::TIME_W'(bt_x3[owu_pkg::BT_W+1:2]);

	assign tick_inc = tick_q + 1'b1;
	assign fire     = (tick_inc >= event_q);

	// next phase
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			owu_pkg::PH_IDLE: begin
				if (mode == owu_pkg::MODE_SEND) begin
					phase_d = owu_pkg::PH_TX;
				end else if (mode == owu_pkg::MODE_BREAK) begin
					phase_d = owu_pkg::PH_BRK;
				end else if (!line_in) begin
					phase_d = owu_pkg::PH_RX;
				end
			end
			owu_pkg::PH_RX: begin
				if (fire && bits_q == 4'd0) begin
					phase_d = owu_pkg::PH_IDLE;
				end
			end
			owu_pkg::PH_TX: begin
				if (fire && bits_q == 4'd0 && !gap_q) begin
					phase_d = owu_pkg::PH_IDLE;
				end
			end
			owu_pkg::PH_BRK: begin
				if (fire && bits_q <= 4'd1) begin
					phase_d = owu_pkg::PH_IDLE;
				end
			end
			default: phase_d = owu_pkg::PH_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		tick_d   = tick_q;
		event_d  = event_q;
		shift_d  = shift_q;
		bits_d   = bits_q;
		gap_d    = gap_q;
		drive_d  = drive_q;
		accepted = 1'b0;
		push     = 1'b0;
		if (phase_q == owu_pkg::PH_IDLE) begin
			tick_d = '0;
			if (mode == owu_pkg::MODE_SEND) begin
				accepted = 1'b1;
				shift_d  = tx_byte;
				bits_d   = owu_pkg::BITS_TX;
				gap_d    = tx_more;
				drive_d  = 1'b1;
				event_d  = bit_time;
			end else if (mode == owu_pkg::MODE_BREAK) begin
				accepted = 1'b1;
				bits_d   = owu_pkg::BITS_BRK;
				drive_d  = 1'b1;
				event_d  = bit_time;
			end else if (!line_in) begin
				shift_d = '0;
				bits_d  = owu_pkg::BITS_RX;
				event_d = first_time;
			end
		end else begin
			tick_d = tick_inc;
			if (fire) begin
				tick_d  = '0;
				event_d = bit_time;
				unique case (phase_q)
					owu_pkg::PH_RX: begin
						if (bits_q != 4'd0) begin
							shift_d = {line_in, shift_q[7:1]};
							bits_d  = bits_q - 4'd1;
							if (bits_q == 4'd1) begin
								push    = 1'b1;
								event_d = stop_time;
							end
						end
					end
					owu_pkg::PH_TX: begin
						if (bits_q > 4'd1) begin
							drive_d = ~shift_q[0];
							shift_d = {1'b0, shift_q[7:1]};
							bits_d  = bits_q - 4'd1;
						end else if (bits_q == 4'd1) begin
							drive_d = 1'b0;
							bits_d  = 4'd0;
						end else if (gap_q) begin
							gap_d = 1'b0;
						end
					end
					owu_pkg::PH_BRK: begin
						if (bits_q != 4'd0) begin
							bits_d = bits_q - 4'd1;
						end
						if (bits_q <= 4'd1) begin
							drive_d = 1'b0;
						end
					end
					default: begin
						bits_d = bits_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= owu_pkg::PH_IDLE;
			tick_q  <= '0;
			event_q <= '0;
			shift_q <= '0;
			bits_q  <= '0;
			gap_q   <= 1'b0;
			drive_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q  <= tick_d;
			event_q <= event_d;
			shift_q <= shift_d;
			bits_q  <= bits_d;
			gap_q   <= gap_d;
			drive_q <= drive_d;
		end
	end

	assign eng.drive     = drive_d;
	assign eng.accepted  = accepted;
	assign eng.push      = push;
	assign eng.push_byte = shift_d;
	assign eng.busy      = (phase_d != owu_pkg::PH_IDLE);

endmodule

[hdl/one_wire_half_duplex_uart.sv]
// ---------------------------------------------------------------------------
// one_wire_half_duplex_uart
// Single-wire half-duplex 8N1 UART with a receive FIFO, one item per tick.
// ---------------------------------------------------------------------------
// Every input item is one tick of the bit timer and gives exactly one result
// item. Items are taken at one per clock whenever in_stall is low; the result
// appears in the output register in the cycle after the item is accepted, and a
// new item can enter in the same cycle the previous result leaves. in_stall is
// high only while a finished result sits in the output register and out_stall
// holds it. The receive bytes live in a synchronous RAM (one write port, one
// registered read port); a pop issues its read in the accept cycle and the
// byte arrives with the result, so pop latency is set by that read port. The
// store needs no clearing after reset: only entries that were written are
// ever popped. The FIFO holds FIFO_DEPTH-1 bytes; a received byte that finds
// it full is dropped. Reception starts on a low line level while idle and no
// command is given; the first data sample is taken max(1.5 bit - trim, 1)
// ticks after the start tick. Send and break are refused (cmd_accepted low)
// while the receiver or transmitter is busy. bit_ticks and center_trim take
// effect from the next bit interval; write them while the block is idle.
// ---------------------------------------------------------------------------
module one_wire_half_duplex_uart (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration
	input  logic                             cfg_we,
	input  logic [owu_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [owu_pkg::CFG_W-1:0]        cfg_data,
	// input items
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       mode,
	input  logic                             line_in,
	input  logic [7:0]                       tx_byte,
	input  logic                             tx_more,
	// result items
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             line_drive,
	output logic                             cmd_accepted,
	output logic                             pop_valid,
	output logic [7:0]                       pop_data,
	output logic [owu_pkg::CNT_W-1:0]        fifo_count,
	output logic                             busy_res
);

	localparam int AW = owu_pkg::FIFO_AW;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		logic [AW-1:0] r;
		if (p == AW'(owu_pkg::FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + 1'b1;
		end
		return r;
	endfunction

	// configuration registers
	logic [owu_pkg::BT_W-1:0]   bit_ticks_q;
	logic [owu_pkg::TRIM_W-1:0] center_trim_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_ticks_q   <= owu_pkg::BIT_TICKS_RST;
			center_trim_q <= owu_pkg::CENTER_TRIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				owu_pkg::REG_BIT_TICKS:   bit_ticks_q   <= cfg_data[owu_pkg::BT_W-1:0];
				owu_pkg::REG_CENTER_TRIM: center_trim_q <= cfg_data[owu_pkg::TRIM_W-1:0];
				default:                  bit_ticks_q   <= bit_ticks_q;
			endcase
		end
	end

	// handshake: stall only when the result register is full and held
	logic accept;
	assign in_stall = out_valid && out_stall;
	assign accept   = in_valid && !in_stall;

	// line engine
	owu_pkg::eng_out_t eng;

	owu_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (accept),
		.mode        (mode),
		.line_in     (line_in),
		.tx_byte     (tx_byte),
		.tx_more     (tx_more),
		.bit_ticks   (bit_ticks_q),
		.center_trim (center_trim_q),
		.eng         (eng)
	);

	// FIFO pointers: pop is handled before the push of the same tick
	logic [AW-1:0] wr_q, rd_q, wr_d, rd_d, count_d;
	logic          pop, push_ok;

	assign pop     = (mode == owu_pkg::MODE_POP) && (rd_q != wr_q);
	assign rd_d    = pop ? ptr_inc(rd_q) : rd_q;
	assign push_ok = eng.push && (ptr_inc(wr_q) != rd_d);
	assign wr_d    = push_ok ? ptr_inc(wr_q) : wr_q;
	assign count_d = (wr_d >= rd_d)
		? wr_d - rd_d
		: AW'(owu_pkg::FIFO_DEPTH - 1) - rd_d + wr_d + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
		end else if (accept) begin
			wr_q <= wr_d;
			rd_q <= rd_d;
		end
	end

	// receive store; the pop read never meets the push write address,
	// since a pop needs a non-empty FIFO and a push writes past the tail
	logic [7:0] rd_byte;

	owu_ram #(
		.WIDTH (8),
		.DEPTH (owu_pkg::FIFO_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (accept && push_ok),
		.waddr (wr_q),
		.wdata (eng.push_byte),
		.re    (accept && pop),
		.raddr (rd_q),
		.rdata (rd_byte)
	);

	// result register
	logic                      drive_s2, acc_s2, popv_s2, busy_s2;
	logic [owu_pkg::CNT_W-1:0] count_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (accept) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			drive_s2 <= eng.drive;
			acc_s2   <= eng.accepted;
			popv_s2  <= pop;
			busy_s2  <= eng.busy;
			count_s2 <= owu_pkg::CNT_W'(count_d);
		end
	end

	// read data register holds while the result waits: no new read issues
	assign line_drive   = drive_s2;
	assign cmd_accepted = acc_s2;
	assign pop_valid    = popv_s2;
	assign pop_data     = popv_s2 ? rd_byte : 8'd0;
	assign fifo_count   = count_s2;
	assign busy_res     = busy_s2;

endmodule

[hdl/owu_checker.sv]
// ---------------------------------------------------------------------------
// owu_checker
// Port-level checks for the one-wire UART, bound to the top level.
// ---------------------------------------------------------------------------
`include "one_wire_half_duplex_uart_defines.svh"

module owu_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_stall,
	input logic                             out_valid,
	input logic                             out_stall,
	input logic                             line_drive,
	input logic                             cmd_accepted,
	input logic                             pop_valid,
	input logic [7:0]                       pop_data,
	input logic [owu_pkg::CNT_W-1:0]        fifo_count,
	input logic                             busy_res
);

	// an accepted item always has its result on the next cycle
	`OWU_ASSERT_NEXT(a_result_follows, in_valid && !in_stall, out_valid, "result missing after accept")

	// a held result does not change
	`OWU_ASSERT_NEXT(a_result_holds, out_valid && out_stall, out_valid && $stable(line_drive) && $stable(pop_data) && $stable(fifo_count), "held result changed")

	// a taken send or break starts by pulling the line and marks busy
	`OWU_ASSERT_SAME(a_cmd_drives, out_valid && cmd_accepted, line_drive && busy_res, "command taken without drive")

	// an empty pop returns zero data
	`OWU_ASSERT_SAME(a_empty_pop_zero, out_valid && !pop_valid, pop_data == 8'd0, "data without pop")

endmodule

bind one_wire_half_duplex_uart owu_checker u_owu_checker (.*);
